### rtl/bmp565_pkg.sv
// ----------------------------------------------------------------------------
// bmp565_pkg
// Shared constants for the 24-bit BMP to RGB565 stream converter: display
// and image limits, parser phase codes, header offsets, result kinds and
// configuration register indexes.
// ----------------------------------------------------------------------------
package bmp565_pkg;

    // Display and image limits
    localparam int DISPLAY_COLUMNS = 320;
    localparam int DISPLAY_ROWS    = 240;
    localparam int MAX_IMAGE_SIDE  = 4096;

    // Width of an image side, column or row counter
    localparam int SIDE_W = $clog2(MAX_IMAGE_SIDE + 1);

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 17;
    localparam int ORIGIN_W = 16;
    localparam int COLOR_W  = 16;
    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;

    // Output beat packing: screen_x, screen_y, color, padded to bytes
    localparam int M_FIELDS_W = 2 * COORD_W + COLOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 2'd1;

    // Parser phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DRAWN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLIPPED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    // Header byte offsets at which a field is complete
    localparam logic [WORD_W-1:0] HDR_SIGNATURE   = 32'd1;
    localparam logic [WORD_W-1:0] HDR_DATA_OFFSET = 32'd13;
    localparam logic [WORD_W-1:0] HDR_WIDTH       = 32'd21;
    localparam logic [WORD_W-1:0] HDR_HEIGHT      = 32'd25;
    localparam logic [WORD_W-1:0] HDR_PLANES      = 32'd27;
    localparam logic [WORD_W-1:0] HDR_BPP         = 32'd29;
    localparam logic [WORD_W-1:0] HDR_COMPRESSION = 32'd33;
    localparam logic [WORD_W-1:0] HDR_END         = 32'd53;

    // Header field values
    localparam logic [15:0]       BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0]       BMP_PLANES    = 16'd1;
    localparam logic [15:0]       BMP_BPP       = 16'd24;
    localparam logic [WORD_W-1:0] MIN_DATA_OFFSET = 32'd54;

endpackage

### rtl/bmp24_to_rgb565_stream.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream
// Parses a 24-bit BMP file arriving one byte per beat and emits one RGB565
// pixel beat per blue-green-red triple, placed at origin plus column and row.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one file byte per beat; s_tuser marks the first byte of a
//   file and restarts the parser on that byte.
//   m_ channel: one beat per decoded pixel, or a single rejection beat
//   (kind rejected, tlast high) at header byte 33 when the header is not a
//   plain uncompressed 24-bit image within the size limit.
//   cfg_ channel: writes origin_x (index 0) and origin_y (index 1); always ready;
//   write only while the stream is idle, which the block itself does not enforce.
// Output: a pixel beat is registered and appears on m_ in the cycle after its red byte is taken.
// Throughput: one byte per cycle while no output beat is stalled; each byte
//   only updates counters and the header shift register, and the pixel
//   repack is fixed wiring, so the single parser state update sets the rate.
// Reset: synchronous, active low; the parser returns to the header phase at
//   byte 0, so the first byte after reset starts a file even without a mark.
// Stall: s_tready falls only while an output beat is held and m_tready is
//   low; the output register then holds its beat unchanged.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_stream (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input bytes
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [bmp565_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] file_byte
    input  logic [0:0]                             s_tuser,   // [0] start_of_file
    // Output pixels
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [bmp565_pkg::M_TDATA_W-1:0]       m_tdata,   // [16:0] screen_x,
                                                              // [33:17] screen_y,
                                                              // [49:34] color,
                                                              // [55:50] zero
    output logic [bmp565_pkg::KIND_W-1:0]          m_tuser,   // [1:0] kind
    output logic                                   m_tlast,   // last
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmp565_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bmp565_pkg::ORIGIN_W-1:0]        cfg_data
);
    import bmp565_pkg::*;

    // Configuration registers
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;

    // Parser state
    logic [WORD_W-1:0]   byte_count_reg,   byte_count_next;
    logic [WORD_W-1:0]   header_shift_reg, header_shift_next;
    logic [WORD_W-1:0]   data_start_reg,   data_start_next;
    logic [SIDE_W-1:0]   image_width_reg,  image_width_next;
    logic [SIDE_W-1:0]   image_height_reg, image_height_next;
    logic                header_ok_reg,    header_ok_next;
    logic [1:0]          phase_reg,        phase_next;
    logic [SIDE_W-1:0]   column_reg,       column_next;
    logic [SIDE_W-1:0]   row_reg,          row_next;
    logic [1:0]          byte_in_pixel_reg, byte_in_pixel_next;
    logic [1:0]          padding_left_reg, padding_left_next;
    logic [15:0]         bg_held_reg,      bg_held_next;

    // Output register
    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg,  m_kind_next;
    logic [COORD_W-1:0]  m_x_reg,     m_x_next;
    logic [COORD_W-1:0]  m_y_reg,     m_y_next;
    logic [COLOR_W-1:0]  m_color_reg, m_color_next;
    logic                m_last_reg,  m_last_next;
    logic                produce;

    // Working values for one byte
    logic [BYTE_W-1:0]   in_byte;
    logic [WORD_W-1:0]   idx;
    logic [WORD_W:0]     idx_plus;
    logic [WORD_W-1:0]   height_mag;
    logic [SIDE_W:0]     column_plus;
    logic [SIDE_W:0]     row_plus;
    logic [COORD_W-1:0]  sx;
    logic [COORD_W-1:0]  sy;
    logic                s_accept;

    assign in_byte  = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, m_color_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // Byte parser: start mark replaces the current state with reset values
    always_comb begin
        byte_count_next    = s_tuser[0] ? '0 : byte_count_reg;
        header_shift_next  = s_tuser[0] ? '0 : header_shift_reg;
        data_start_next    = s_tuser[0] ? '0 : data_start_reg;
        image_width_next   = s_tuser[0] ? '0 : image_width_reg;
        image_height_next  = s_tuser[0] ? '0 : image_height_reg;
        header_ok_next     = s_tuser[0] ? 1'b1 : header_ok_reg;
        phase_next         = s_tuser[0] ? PH_HEADER : phase_reg;
        column_next        = s_tuser[0] ? '0 : column_reg;
        row_next           = s_tuser[0] ? '0 : row_reg;
        byte_in_pixel_next = s_tuser[0] ? '0 : byte_in_pixel_reg;
        padding_left_next  = s_tuser[0] ? '0 : padding_left_reg;
        bg_held_next       = s_tuser[0] ? '0 : bg_held_reg;

        idx        = byte_count_next;
        idx_plus   = {1'b0, idx} + {{WORD_W{1'b0}}, 1'b1};
        height_mag = '0;

        sx          = {1'b0, origin_x_reg} + {{(COORD_W - SIDE_W){1'b0}}, column_next};
        sy          = {1'b0, origin_y_reg} + {{(COORD_W - SIDE_W){1'b0}}, row_next};
        column_plus = {1'b0, column_next} + {{SIDE_W{1'b0}}, 1'b1};
        row_plus    = {1'b0, row_next} + {{SIDE_W{1'b0}}, 1'b1};

        produce      = 1'b0;
        m_kind_next  = KIND_DRAWN;
        m_x_next     = '0;
        m_y_next     = '0;
        m_color_next = '0;
        m_last_next  = 1'b0;

        unique case (phase_next)
            PH_HEADER: begin
                header_shift_next = {in_byte, header_shift_next[WORD_W-1:BYTE_W]};
                case (idx)
                    HDR_SIGNATURE: begin
                        if (header_shift_next[31:16] != BMP_SIGNATURE) header_ok_next = 1'b0;
                    end
                    HDR_DATA_OFFSET: begin
                        data_start_next = header_shift_next;
                        if (header_shift_next < MIN_DATA_OFFSET) header_ok_next = 1'b0;
                    end
                    HDR_WIDTH: begin
                        if (header_shift_next[WORD_W-1]) begin
                            image_width_next = '0;
                        end else if (header_shift_next > WORD_W'(MAX_IMAGE_SIDE)) begin
                            header_ok_next = 1'b0;
                        end else begin
                            image_width_next = header_shift_next[SIDE_W-1:0];
                        end
                    end
                    HDR_HEIGHT: begin
                        height_mag = header_shift_next[WORD_W-1] ? (~header_shift_next + 1'b1)
                                                                 : header_shift_next;
                        if (height_mag > WORD_W'(MAX_IMAGE_SIDE)) header_ok_next = 1'b0;
                        else image_height_next = height_mag[SIDE_W-1:0];
                    end
                    HDR_PLANES: begin
                        if (header_shift_next[31:16] != BMP_PLANES) header_ok_next = 1'b0;
                    end
                    HDR_BPP: begin
                        if (header_shift_next[31:16] != BMP_BPP) header_ok_next = 1'b0;
                    end
                    HDR_COMPRESSION: begin
                        if (header_shift_next != '0) header_ok_next = 1'b0;
                        if (!header_ok_next) begin
                            phase_next  = PH_DONE;
                            produce     = 1'b1;
                            m_kind_next = KIND_REJECTED;
                            m_last_next = 1'b1;
                        end else if (image_width_next == '0 || image_height_next == '0) begin
                            phase_next = PH_DONE;
                        end
                    end
                    HDR_END: begin
                        phase_next = (data_start_next <= MIN_DATA_OFFSET) ? PH_PIXELS : PH_SKIP;
                    end
                    default: begin
                    end
                endcase
            end
            PH_SKIP: begin
                if (idx_plus >= {1'b0, data_start_next}) phase_next = PH_PIXELS;
            end
            PH_PIXELS: begin
                if (padding_left_next != 2'd0) begin
                    padding_left_next = padding_left_next - 2'd1;
                end else if (byte_in_pixel_next == 2'd0) begin
                    bg_held_next[7:0]  = in_byte;
                    byte_in_pixel_next = 2'd1;
                end else if (byte_in_pixel_next == 2'd1) begin
                    bg_held_next[15:8] = in_byte;
                    byte_in_pixel_next = 2'd2;
                end else begin
                    // Red byte completes the pixel
                    byte_in_pixel_next = 2'd0;
                    produce      = 1'b1;
                    m_color_next = {in_byte[7:3], bg_held_next[15:10], bg_held_next[7:3]};
                    m_x_next     = sx;
                    m_y_next     = sy;
                    m_kind_next  = (sx < COORD_W'(DISPLAY_COLUMNS) && sy < COORD_W'(DISPLAY_ROWS))
                                   ? KIND_DRAWN : KIND_CLIPPED;
                    if (column_plus >= {1'b0, image_width_next}) begin
                        column_next = '0;
                        if (row_plus >= {1'b0, image_height_next}) begin
                            m_last_next = 1'b1;
                            phase_next  = PH_DONE;
                        end else begin
                            row_next          = row_plus[SIDE_W-1:0];
                            padding_left_next = image_width_next[1:0];
                        end
                    end else begin
                        column_next = column_plus[SIDE_W-1:0];
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Saturating byte counter
        if (idx != '1) byte_count_next = idx_plus[WORD_W-1:0];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ORIGIN_X) origin_x_reg <= cfg_data;
            if (cfg_index == CFG_ORIGIN_Y) origin_y_reg <= cfg_data;
        end
    end

    // Parser state update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            header_shift_reg  <= '0;
            data_start_reg    <= '0;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            header_ok_reg     <= 1'b1;
            phase_reg         <= PH_HEADER;
            column_reg        <= '0;
            row_reg           <= '0;
            byte_in_pixel_reg <= '0;
            padding_left_reg  <= '0;
            bg_held_reg       <= '0;
        end else if (s_accept) begin
            byte_count_reg    <= byte_count_next;
            header_shift_reg  <= header_shift_next;
            data_start_reg    <= data_start_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            header_ok_reg     <= header_ok_next;
            phase_reg         <= phase_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            padding_left_reg  <= padding_left_next;
            bg_held_reg       <= bg_held_next;
        end
    end

    // Output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= produce;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded only with a new beat
    always_ff @(posedge aclk) begin
        if (s_accept && produce) begin
            m_kind_reg  <= m_kind_next;
            m_x_reg     <= m_x_next;
            m_y_reg     <= m_y_next;
            m_color_reg <= m_color_next;
            m_last_reg  <= m_last_next;
        end
    end

endmodule
